// File: rtl/core/vm5_pkg.sv
`default_nettype none

package vm5_pkg;

  localparam int DefaultMaxLineWidth = 1024;
  localparam int WindowRows          = 5;
  localparam int StoreRows           = WindowRows - 1;
  localparam int SlotW               = $clog2(StoreRows);
  localparam int PixelW              = 8;
  localparam int LineWidthW          = 11;
  localparam int FrameHeightW        = 13;
  localparam int RowW                = 12;
  localparam int HeightMax           = 4096;
  localparam int LineWidthReset      = 512;
  localparam int FrameHeightReset    = 512;
  localparam int CfgDataW            = FrameHeightW;
  localparam int QueueDepth          = 4;

  typedef enum logic [0:0] {
    CfgLineWidth   = 1'b0,
    CfgFrameHeight = 1'b1
  } cfg_index_e;

  typedef logic [StoreRows-1:0][PixelW-1:0] store_rows_t;

  // Item handed from the front stage to the median stage
  typedef struct packed {
    logic [SlotW-1:0]  slot;
    logic [PixelW-1:0] pixel;
    logic              line_end;
    logic              frame_end;
  } front_item_t;

  function automatic logic [PixelW-1:0] min8(input logic [PixelW-1:0] x,
                                             input logic [PixelW-1:0] y);
    return (x < y) ? x : y;
  endfunction

  function automatic logic [PixelW-1:0] max8(input logic [PixelW-1:0] x,
                                             input logic [PixelW-1:0] y);
    return (x > y) ? x : y;
  endfunction

  // a..d are rows r-4..r-1, e is the new pixel of row r
  function automatic logic [PixelW-1:0] median5(input logic [PixelW-1:0] a,
                                                input logic [PixelW-1:0] b,
                                                input logic [PixelW-1:0] c,
                                                input logic [PixelW-1:0] d,
                                                input logic [PixelW-1:0] e);
    logic [PixelW-1:0] lo;
    logic [PixelW-1:0] hi;
    lo = max8(min8(a, b), min8(c, d));
    hi = min8(max8(a, b), max8(c, d));
    return max8(min8(e, lo), min8(hi, max8(e, lo)));
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/vm5_line_store.sv
`default_nettype none

module vm5_line_store #(
  parameter int MAX_LINE_WIDTH = vm5_pkg::DefaultMaxLineWidth
) (
  input  wire logic                                clk_i,
  input  wire logic                                en_i,
  input  wire logic [$clog2(MAX_LINE_WIDTH)-1:0]   addr_i,
  input  wire logic [vm5_pkg::SlotW-1:0]           slot_i,
  input  wire logic [vm5_pkg::PixelW-1:0]          wdata_i,
  output      vm5_pkg::store_rows_t                rdata_o
);
  import vm5_pkg::*;

  logic [PixelW-1:0] rdata_q [StoreRows];

  // One bank per stored row; read all banks, write the oldest one in place
  for (genvar g = 0; g < StoreRows; g++) begin : g_bank
    logic [PixelW-1:0] mem [MAX_LINE_WIDTH];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rdata_q[g] <= mem[addr_i];
        if (slot_i == SlotW'(g)) begin
          mem[addr_i] <= wdata_i;
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < StoreRows; k++) begin
      rdata_o[k] = rdata_q[k];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/vm5_front.sv
`default_nettype none

module vm5_front #(
  parameter int MAX_LINE_WIDTH = vm5_pkg::DefaultMaxLineWidth
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_valid_i,
  output      logic                               cfg_ready_o,
  input  wire logic                               cfg_index_i,
  input  wire logic [vm5_pkg::CfgDataW-1:0]       cfg_data_i,
  input  wire logic                               in_valid_i,
  output      logic                               in_ready_o,
  input  wire logic [vm5_pkg::PixelW-1:0]         in_pixel_i,
  input  wire logic                               in_sof_i,
  output      logic                               store_en_o,
  output      logic [$clog2(MAX_LINE_WIDTH)-1:0]  store_addr_o,
  output      logic [vm5_pkg::SlotW-1:0]          store_slot_o,
  output      logic                               item_valid_o,
  output      vm5_pkg::front_item_t               item_o,
  input  wire logic                               item_ready_i
);
  import vm5_pkg::*;

  localparam int ColW    = $clog2(MAX_LINE_WIDTH);
  localparam int CmpW    = ((ColW > LineWidthW) ? ColW : LineWidthW) + 1;
  localparam int ResetWm1 =
    ((LineWidthReset > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH : LineWidthReset) - 1;
  localparam int ResetHm1 = FrameHeightReset - 1;

  logic [CmpW-1:0]         wm1_q, wm1_d;
  logic [FrameHeightW-1:0] hm1_q, hm1_d;
  logic [ColW-1:0]         col_q, col_d, col_cur;
  logic [RowW-1:0]         row_q, row_d, row_cur;
  logic                    last_col, last_row, has_result, accept;
  logic                    item_valid_q, item_valid_d;
  front_item_t             item_q;
  logic [CmpW-1:0]         lw_ext;

  assign cfg_ready_o = 1'b1;

  // Keep width-1 and height-1 clamped to their legal ranges
  always_comb begin
    wm1_d  = wm1_q;
    hm1_d  = hm1_q;
    lw_ext = CmpW'(cfg_data_i[LineWidthW-1:0]);
    if (cfg_valid_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CfgLineWidth: begin
          if (lw_ext == '0) begin
            wm1_d = '0;
          end else if (lw_ext > CmpW'(MAX_LINE_WIDTH)) begin
            wm1_d = CmpW'(MAX_LINE_WIDTH - 1);
          end else begin
            wm1_d = lw_ext - CmpW'(1);
          end
        end
        CfgFrameHeight: begin
          if (cfg_data_i < FrameHeightW'(WindowRows)) begin
            hm1_d = FrameHeightW'(WindowRows - 1);
          end else if (cfg_data_i > FrameHeightW'(HeightMax)) begin
            hm1_d = FrameHeightW'(HeightMax - 1);
          end else begin
            hm1_d = cfg_data_i - FrameHeightW'(1);
          end
        end
      endcase
    end
  end

  assign in_ready_o = !item_valid_q || item_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    col_cur    = in_sof_i ? '0 : col_q;
    row_cur    = in_sof_i ? '0 : row_q;
    last_col   = CmpW'(col_cur) >= wm1_q;
    last_row   = FrameHeightW'(row_cur) >= hm1_q;
    has_result = row_cur >= RowW'(StoreRows);

    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_cur + RowW'(1);
      end else begin
        col_d = col_cur + ColW'(1);
        row_d = row_cur;
      end
    end

    item_valid_d = item_valid_q;
    if (accept) begin
      item_valid_d = has_result;
    end else if (item_ready_i) begin
      item_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wm1_q        <= CmpW'(ResetWm1);
      hm1_q        <= FrameHeightW'(ResetHm1);
      col_q        <= '0;
      row_q        <= '0;
      item_valid_q <= 1'b0;
    end else begin
      wm1_q        <= wm1_d;
      hm1_q        <= hm1_d;
      col_q        <= col_d;
      row_q        <= row_d;
      item_valid_q <= item_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.slot      <= row_cur[SlotW-1:0];
      item_q.pixel     <= in_pixel_i;
      item_q.line_end  <= last_col;
      item_q.frame_end <= last_col && last_row;
    end
  end

  assign store_en_o   = accept;
  assign store_addr_o = col_cur;
  assign store_slot_o = row_cur[SlotW-1:0];
  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

// File: rtl/core/vm5_back.sv
`default_nettype none

module vm5_back (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        item_valid_i,
  input  wire vm5_pkg::front_item_t        item_i,
  input  wire vm5_pkg::store_rows_t        rows_i,
  output      logic                        item_ready_o,
  output      logic                        out_valid_o,
  input  wire logic                        out_ready_i,
  output      logic [vm5_pkg::PixelW-1:0]  out_median_o,
  output      logic                        out_line_end_o,
  output      logic                        out_frame_end_o
);
  import vm5_pkg::*;

  localparam int PtrW = $clog2(QueueDepth);
  localparam int CntW = PtrW + 1;

  typedef struct packed {
    logic [PixelW-1:0] median;
    logic              line_end;
    logic              frame_end;
  } result_t;

  result_t           queue_q [QueueDepth];
  result_t           res;
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push, pop;
  logic [PixelW-1:0] a, b, c, d;

  // Rotate the banks so a is the oldest row of this column
  always_comb begin
    a = rows_i[item_i.slot];
    b = rows_i[item_i.slot + SlotW'(1)];
    c = rows_i[item_i.slot + SlotW'(2)];
    d = rows_i[item_i.slot + SlotW'(3)];
    res.median    = median5(a, b, c, d, item_i.pixel);
    res.line_end  = item_i.line_end;
    res.frame_end = item_i.frame_end;
  end

  assign item_ready_o = count_q != CntW'(QueueDepth);
  assign push         = item_valid_i && item_ready_o;
  assign out_valid_o  = count_q != '0;
  assign pop          = out_valid_o && out_ready_i;

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q + CntW'(push) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= res;
    end
  end

  assign out_median_o    = queue_q[rd_ptr_q].median;
  assign out_line_end_o  = queue_q[rd_ptr_q].line_end;
  assign out_frame_end_o = queue_q[rd_ptr_q].frame_end;

endmodule

`default_nettype wire

// File: rtl/core/vertical_median5_filter.sv
// Vertical 5-tap median over a raster pixel stream, one pixel per item.
// Each result passes the front item register and then the back result queue
// before it is offered; pixels of rows 0 to 3 of a frame give no result.
// Throughput: 1 item per cycle unless the output stalls; the line store read and write share one edge.
// Reset: row and column counts clear, width and height return to 512;
// line store contents stay undefined, so no clearing pass is run.
`default_nettype none

module vertical_median5_filter #(
  parameter int MAX_LINE_WIDTH = vm5_pkg::DefaultMaxLineWidth
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_valid_i,
  output      logic                          cfg_ready_o,
  input  wire logic                          cfg_index_i,
  input  wire logic [vm5_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                          s_axis_tvalid,
  output      logic                          s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // [7:0] pixel
  input  wire logic                          s_axis_tuser,  // [0] start_of_frame
  output      logic                          m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output      logic [7:0]                    m_axis_tdata,  // [7:0] median
  output      logic                          m_axis_tlast,  // line_end
  output      logic                          m_axis_tuser   // [0] frame_end
);
  import vm5_pkg::*;

  localparam int ColW = $clog2(MAX_LINE_WIDTH);

  logic              store_en;
  logic [ColW-1:0]   store_addr;
  logic [SlotW-1:0]  store_slot;
  store_rows_t       store_rows;
  logic              item_valid, item_ready;
  front_item_t       item;

  vm5_front #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_pixel_i   (s_axis_tdata),
    .in_sof_i     (s_axis_tuser),
    .store_en_o   (store_en),
    .store_addr_o (store_addr),
    .store_slot_o (store_slot),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_ready_i (item_ready)
  );

  vm5_line_store #(
    .MAX_LINE_WIDTH (MAX_LINE_WIDTH)
  ) u_line_store (
    .clk_i   (clk_i),
    .en_i    (store_en),
    .addr_i  (store_addr),
    .slot_i  (store_slot),
    .wdata_i (s_axis_tdata),
    .rdata_o (store_rows)
  );

  vm5_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (item_valid),
    .item_i          (item),
    .rows_i          (store_rows),
    .item_ready_o    (item_ready),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .out_median_o    (m_axis_tdata),
    .out_line_end_o  (m_axis_tlast),
    .out_frame_end_o (m_axis_tuser)
  );

endmodule

`default_nettype wire
